// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ACRS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define ACRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acrs_pkg.sv =====
// ----------------------------------------------------------------------------
// acrs_pkg
// Shared types, codes and reset values for the converter readout sequencer.
// ----------------------------------------------------------------------------
package acrs_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 3;
    localparam int CHCNT_W    = 4;
    localparam int TICK_W     = 16;
    localparam int HALF_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0]  CONVERT_PULSE_RST = 16'd10;
    localparam logic [TICK_W-1:0]  BUSY_TIMEOUT_RST  = 16'd10000;
    localparam logic [TICK_W-1:0]  SELECT_SETUP_RST  = 16'd1;
    localparam logic [HALF_W-1:0]  CLOCK_HALF_RST    = 8'd1;
    localparam logic [CHCNT_W-1:0] CHANNELS_RST      = 4'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CONVERT,
        PH_WAIT,
        PH_SETUP,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WORKING = 2'd1,
        ST_DONE    = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONVERT_PULSE = 3'd0,
        REG_BUSY_TIMEOUT  = 3'd1,
        REG_SELECT_SETUP  = 3'd2,
        REG_CLOCK_HALF    = 3'd3,
        REG_CHANNELS      = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0]  convert_pulse;
        logic [TICK_W-1:0]  busy_timeout;
        logic [TICK_W-1:0]  select_setup;
        logic [HALF_W-1:0]  clock_half;
        logic [CHCNT_W-1:0] channels;
    } cfg_t;

    typedef struct packed {
        logic                       convert_n;
        logic                       select_n;
        logic                       serial_clock;
        logic                       sample_valid;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_channel;
        status_t                    status;
        logic [COUNT_W-1:0]         errors_seen;
        logic [COUNT_W-1:0]         reads_done;
    } result_t;

endpackage

// ===== hdl/adc_conversion_readout_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// adc_conversion_readout_sequencer_unit
// Converter readout sequencer: convert pulse, busy wait, serial readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request per tick carrying kind
//   (0 plain tick, 1 start), busy_pin and data_pin as sampled from the pins.
//   Output channel (out_valid/out_ready): exactly one result per request
//   with line levels, sample fields, status and the two counters.
//   Config port (cfg_we/cfg_index/cfg_wdata): write only while idle.
//   Path: a request waits in the input register until the result slot frees,
//   and its result is then loaded into the output register.
//   Throughput: one request per cycle while out_ready stays high; the
//   sequencer state loop closes through the phase/tick update logic.
//   Stall: when the receiver holds out_ready low, the result holds, the
//   input register holds the next request and in_ready drops once both are
//   full; nothing is lost or repeated.
//   Reset: phase idle, counters zero, config registers to their defaults,
//   both channel registers empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_conversion_readout_sequencer_unit #(
    parameter int MAX_CHANNELS = acrs_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = acrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [acrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic                                busy_pin,
    input  logic                                data_pin,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                convert_n,
    output logic                                select_n,
    output logic                                serial_clock,
    output logic                                sample_valid,
    output logic [acrs_pkg::CHAN_W-1:0]         channel,
    output logic signed [acrs_pkg::SAMPLE_W-1:0] sample,
    output logic                                last_channel,
    output logic [1:0]                          status,
    output logic [acrs_pkg::COUNT_W-1:0]        errors_seen,
    output logic [acrs_pkg::COUNT_W-1:0]        reads_done
);
    import acrs_pkg::*;

    cfg_t    cfg;
    result_t step_result;
    result_t held_result;

    // Input register: one request waiting for the sequencer.
    logic    in_full_reg, in_full_next;
    logic    kind_reg, busy_reg, data_reg;
    logic    can_load;
    logic    advance;
    logic    in_take;

    // Move the held request into the sequencer when the result slot frees.
    assign advance      = in_full_reg && can_load;
    assign in_ready     = !in_full_reg || advance;
    assign in_take      = in_valid && in_ready;
    assign in_full_next = in_take || (in_full_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            busy_reg <= busy_pin;
            data_reg <= data_pin;
        end
    end

    acrs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acrs_core #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .step     (advance),
        .start    (kind_reg),
        .busy     (busy_reg),
        .data_bit (data_reg),
        .result   (step_result)
    );

    acrs_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (step_result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (held_result)
    );

    // Drive the result fields.
    assign convert_n    = held_result.convert_n;
    assign select_n     = held_result.select_n;
    assign serial_clock = held_result.serial_clock;
    assign sample_valid = held_result.sample_valid;
    assign channel      = held_result.channel;
    assign sample       = held_result.sample;
    assign last_channel = held_result.last_channel;
    assign status       = held_result.status;
    assign errors_seen  = held_result.errors_seen;
    assign reads_done   = held_result.reads_done;

    // A mid-frame sample lands on a falling clock with select still low.
    `ACRS_ASSERT_IMPLY(a_mid_sample_lines, out_valid && sample_valid && !last_channel, !select_n && !serial_clock, "mid-frame sample without select low and clock low")
    // The final sample closes the frame.
    `ACRS_ASSERT_IMPLY(a_last_closes, out_valid && last_channel, sample_valid && select_n && (status == ST_DONE), "final sample does not end the readout")
    // A timeout leaves every line released and carries no sample.
    `ACRS_ASSERT_IMPLY(a_timeout_lines, out_valid && (status == ST_TIMEOUT), convert_n && select_n && !sample_valid, "timeout result with lines or sample active")
    // Convert and select are never low together.
    `ACRS_ASSERT_ALWAYS(a_convert_select, !out_valid || convert_n || select_n, "convert and select low at once")

endmodule

// ===== hdl/acrs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acrs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module acrs_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [acrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acrs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output acrs_pkg::cfg_t                     cfg
);
    import acrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_CONVERT_PULSE: cfg_next.convert_pulse = cfg_wdata;
                REG_BUSY_TIMEOUT:  cfg_next.busy_timeout  = cfg_wdata;
                REG_SELECT_SETUP:  cfg_next.select_setup  = cfg_wdata;
                REG_CLOCK_HALF:    cfg_next.clock_half    = cfg_wdata[HALF_W-1:0];
                REG_CHANNELS:      cfg_next.channels      = cfg_wdata[CHCNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.convert_pulse <= CONVERT_PULSE_RST;
            cfg_reg.busy_timeout  <= BUSY_TIMEOUT_RST;
            cfg_reg.select_setup  <= SELECT_SETUP_RST;
            cfg_reg.clock_half    <= CLOCK_HALF_RST;
            cfg_reg.channels      <= CHANNELS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/acrs_core.sv =====
// ----------------------------------------------------------------------------
// acrs_core
// Sequencer state and one-request update: convert pulse, busy wait, setup,
// serial shift and saturating counters.
// ----------------------------------------------------------------------------
module acrs_core #(
    parameter int MAX_CHANNELS = acrs_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = acrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  acrs_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic              start,
    input  logic              busy,
    input  logic              data_bit,
    output acrs_pkg::result_t result
);
    import acrs_pkg::*;

    localparam int BIT_W = $clog2(SAMPLE_BITS);
    localparam logic [BIT_W-1:0]   BIT_TOP = BIT_W'(SAMPLE_BITS - 1);
    localparam logic [CHCNT_W-1:0] CH_MAX  = CHCNT_W'(MAX_CHANNELS);

    phase_t                   phase_reg, phase_next;
    logic [TICK_W-1:0]        tick_reg, tick_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic [SAMPLE_BITS-1:0]   shift_reg, shift_next;
    logic [COUNT_W-1:0]       timeout_total_reg, timeout_total_next;
    logic [COUNT_W-1:0]       readout_total_reg, readout_total_next;

    logic [TICK_W:0]          tick_inc;
    logic [CHCNT_W-1:0]       used_ch;
    logic [CHCNT_W-1:0]       chan_plus;
    logic [SAMPLE_BITS-1:0]   shift_in;
    logic                     half_done;
    logic                     bit_last;
    logic                     last_hit;
    logic                     sample_fire;
    logic                     last_fire;
    status_t                  status_code;

    assign tick_inc  = {1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign half_done = tick_reg >= {{(TICK_W - HALF_W){1'b0}}, cfg.clock_half};
    assign bit_last  = bit_reg == '0;
    assign chan_plus = {1'b0, chan_reg} + {{(CHCNT_W - 1){1'b0}}, 1'b1};
    assign last_hit  = chan_plus >= used_ch;
    assign shift_in  = {shift_reg[SAMPLE_BITS-2:0], data_bit};

    // Clamp the channel count into 1..MAX_CHANNELS.
    always_comb
    begin
        if (cfg.channels == '0)
            used_ch = {{(CHCNT_W - 1){1'b0}}, 1'b1};
        else if (cfg.channels > CH_MAX)
            used_ch = CH_MAX;
        else
            used_ch = cfg.channels;
    end

    // Next phase.
    always_comb
    begin
        case (phase_reg)
            PH_IDLE:
                phase_next = start ? PH_CONVERT : PH_IDLE;
            PH_CONVERT:
                phase_next = (tick_reg >= cfg.convert_pulse) ? PH_WAIT : PH_CONVERT;
            PH_WAIT:
                if (!busy)
                    phase_next = (cfg.select_setup == '0) ? PH_HIGH : PH_SETUP;
                else if (tick_inc >= {1'b0, cfg.busy_timeout})
                    phase_next = PH_IDLE;
                else
                    phase_next = PH_WAIT;
            PH_SETUP:
                phase_next = (tick_inc >= {1'b0, cfg.select_setup}) ? PH_HIGH : PH_SETUP;
            PH_HIGH:
                if (!half_done)
                    phase_next = PH_HIGH;
                else if (bit_last && last_hit)
                    phase_next = PH_IDLE;
                else
                    phase_next = PH_LOW;
            PH_LOW:
                phase_next = half_done ? PH_HIGH : PH_LOW;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // Counters, shift word and per-request flags.
    always_comb
    begin
        tick_next          = tick_reg;
        bit_next           = bit_reg;
        chan_next          = chan_reg;
        shift_next         = shift_reg;
        timeout_total_next = timeout_total_reg;
        readout_total_next = readout_total_reg;
        sample_fire        = 1'b0;
        last_fire          = 1'b0;
        status_code        = ST_WORKING;
        case (phase_reg)
            PH_IDLE:
                if (start)
                begin
                    tick_next  = TICK_W'(1);
                    bit_next   = BIT_TOP;
                    chan_next  = '0;
                    shift_next = '0;
                end
                else
                begin
                    status_code = ST_IDLE;
                end
            PH_CONVERT:
                if (tick_reg >= cfg.convert_pulse)
                    tick_next = '0;
                else
                    tick_next = tick_inc[TICK_W-1:0];
            PH_WAIT:
                if (!busy)
                begin
                    tick_next = (cfg.select_setup == '0) ? TICK_W'(1) : '0;
                end
                else if (tick_inc >= {1'b0, cfg.busy_timeout})
                begin
                    if (timeout_total_reg != COUNT_MAX)
                        timeout_total_next = timeout_total_reg + COUNT_W'(1);
                    tick_next   = '0;
                    status_code = ST_TIMEOUT;
                end
                else
                begin
                    tick_next = tick_inc[TICK_W-1:0];
                end
            PH_SETUP:
                if (tick_inc >= {1'b0, cfg.select_setup})
                    tick_next = TICK_W'(1);
                else
                    tick_next = tick_inc[TICK_W-1:0];
            PH_HIGH:
                if (!half_done)
                begin
                    tick_next = tick_inc[TICK_W-1:0];
                end
                else if (!bit_last)
                begin
                    shift_next = shift_in;
                    bit_next   = bit_reg - BIT_W'(1);
                    tick_next  = TICK_W'(1);
                end
                else
                begin
                    // Falling edge of the final bit: present the word.
                    sample_fire = 1'b1;
                    shift_next  = '0;
                    bit_next    = BIT_TOP;
                    if (last_hit)
                    begin
                        last_fire = 1'b1;
                        if (readout_total_reg != COUNT_MAX)
                            readout_total_next = readout_total_reg + COUNT_W'(1);
                        tick_next   = '0;
                        chan_next   = '0;
                        status_code = ST_DONE;
                    end
                    else
                    begin
                        chan_next = chan_plus[CHAN_W-1:0];
                        tick_next = TICK_W'(1);
                    end
                end
            PH_LOW:
                if (half_done)
                    tick_next = TICK_W'(1);
                else
                    tick_next = tick_inc[TICK_W-1:0];
            default:
            begin
                tick_next   = '0;
                status_code = ST_IDLE;
            end
        endcase
    end

    // Result fields, line levels after this update.
    always_comb
    begin
        result.convert_n    = phase_next != PH_CONVERT;
        result.select_n     = !(phase_next == PH_SETUP || phase_next == PH_HIGH
                                || phase_next == PH_LOW);
        result.serial_clock = phase_next == PH_HIGH;
        result.sample_valid = sample_fire;
        result.channel      = sample_fire ? chan_reg : '0;
        result.sample       = sample_fire ? SAMPLE_W'($signed(shift_in)) : '0;
        result.last_channel = last_fire;
        result.status       = status_code;
        result.errors_seen  = timeout_total_next;
        result.reads_done   = readout_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            tick_reg          <= '0;
            bit_reg           <= BIT_TOP;
            chan_reg          <= '0;
            shift_reg         <= '0;
            timeout_total_reg <= '0;
            readout_total_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            tick_reg          <= tick_next;
            bit_reg           <= bit_next;
            chan_reg          <= chan_next;
            shift_reg         <= shift_next;
            timeout_total_reg <= timeout_total_next;
            readout_total_reg <= readout_total_next;
        end
    end

endmodule

// ===== hdl/acrs_out_reg.sv =====
// ----------------------------------------------------------------------------
// acrs_out_reg
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module acrs_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  acrs_pkg::result_t result_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output acrs_pkg::result_t result_out
);
    import acrs_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the converter readout sequencer. Requests are
// generated against the predicted sequencer phase. Each accepted request is
// run through an in-bench readout predictor. Each result from the block is
// compared field by field with the oldest prediction. Both channels idle and
// stall at random, and the registers are reloaded between setting phases.
// ----------------------------------------------------------------------------
module tb_top;
    import acrs_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;

    // ------------------------------------------------------------------------
    // Readout predictor and result store. note_request() advances the
    // predicted sequencer by one request and queues the line levels, sample
    // fields and counters that the block must report for it.
    // ------------------------------------------------------------------------
    class readout_scoreboard;
        logic [TICK_W-1:0]  pulse_ticks;
        logic [TICK_W-1:0]  timeout_ticks;
        logic [TICK_W-1:0]  setup_ticks;
        logic [HALF_W-1:0]  half_ticks;
        logic [CHCNT_W-1:0] chan_count;

        phase_t             phase;
        int unsigned        tick_cnt;
        logic [3:0]         bit_idx;
        logic [CHAN_W-1:0]  chan_idx;
        logic [SAMPLE_W-1:0] shift_reg;
        logic [COUNT_W-1:0] timeouts;
        logic [COUNT_W-1:0] readouts;

        result_t            pending[$];
        int                 failures;
        int                 requests;
        int                 checked;
        int                 samples;

        function new();
            pulse_ticks   = CONVERT_PULSE_RST;
            timeout_ticks = BUSY_TIMEOUT_RST;
            setup_ticks   = SELECT_SETUP_RST;
            half_ticks    = CLOCK_HALF_RST;
            chan_count    = CHANNELS_RST;
            phase         = PH_IDLE;
            tick_cnt      = 0;
            bit_idx       = 4'd15;
            chan_idx      = '0;
            shift_reg     = '0;
            timeouts      = '0;
            readouts      = '0;
            failures      = 0;
            requests      = 0;
            checked       = 0;
            samples       = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_CONVERT_PULSE: pulse_ticks   = val;
                REG_BUSY_TIMEOUT:  timeout_ticks = val;
                REG_SELECT_SETUP:  setup_ticks   = val;
                REG_CLOCK_HALF:    half_ticks    = val[HALF_W-1:0];
                REG_CHANNELS:      chan_count    = val[CHCNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_channels();
            if (chan_count == 0) return 1;
            if (chan_count > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
            return int'(chan_count);
        endfunction

        function void start_bit();
            phase    = PH_HIGH;
            tick_cnt = 1;
        endfunction

        function result_t note_request(logic start, logic busy, logic din);
            result_t want;
            status_t st;
            want = '0;
            st   = ST_WORKING;
            requests++;
            case (phase)
                PH_IDLE: begin
                    if (start) begin
                        phase     = PH_CONVERT;
                        tick_cnt  = 1;
                        bit_idx   = 4'd15;
                        chan_idx  = '0;
                        shift_reg = '0;
                    end
                    else begin
                        st = ST_IDLE;
                    end
                end
                PH_CONVERT: begin
                    if (tick_cnt >= pulse_ticks) begin
                        phase    = PH_WAIT;
                        tick_cnt = 0;
                    end
                    else begin
                        tick_cnt++;
                    end
                end
                PH_WAIT: begin
                    if (!busy) begin
                        if (setup_ticks == 0) start_bit();
                        else begin
                            phase    = PH_SETUP;
                            tick_cnt = 0;
                        end
                    end
                    else begin
                        tick_cnt++;
                        if (tick_cnt >= timeout_ticks) begin
                            if (timeouts != COUNT_MAX) timeouts++;
                            phase    = PH_IDLE;
                            tick_cnt = 0;
                            st       = ST_TIMEOUT;
                        end
                    end
                end
                PH_SETUP: begin
                    tick_cnt++;
                    if (tick_cnt >= setup_ticks) start_bit();
                end
                PH_HIGH: begin
                    if (tick_cnt >= half_ticks) begin
                        // falling edge: take the data bit
                        shift_reg = {shift_reg[SAMPLE_W-2:0], din};
                        if (bit_idx == 0) begin
                            want.sample_valid = 1'b1;
                            want.channel      = chan_idx;
                            want.sample       = shift_reg;
                            shift_reg         = '0;
                            bit_idx           = 4'd15;
                            samples++;
                            if (int'(chan_idx) + 1 >= active_channels()) begin
                                want.last_channel = 1'b1;
                                if (readouts != COUNT_MAX) readouts++;
                                phase    = PH_IDLE;
                                tick_cnt = 0;
                                chan_idx = '0;
                                st       = ST_DONE;
                            end
                            else begin
                                chan_idx = chan_idx + 1'b1;
                                phase    = PH_LOW;
                                tick_cnt = 1;
                            end
                        end
                        else begin
                            bit_idx  = bit_idx - 1'b1;
                            phase    = PH_LOW;
                            tick_cnt = 1;
                        end
                    end
                    else begin
                        tick_cnt++;
                    end
                end
                PH_LOW: begin
                    if (tick_cnt >= half_ticks) start_bit();
                    else tick_cnt++;
                end
                default: begin
                    phase    = PH_IDLE;
                    tick_cnt = 0;
                    st       = ST_IDLE;
                end
            endcase

            want.convert_n    = (phase != PH_CONVERT);
            want.select_n     = !(phase == PH_SETUP || phase == PH_HIGH || phase == PH_LOW);
            want.serial_clock = (phase == PH_HIGH);
            want.status       = st;
            want.errors_seen  = timeouts;
            want.reads_done   = readouts;
            pending.push_back(want);
            return want;
        endfunction

        function string show(result_t r);
            return $sformatf(
                "conv=%b sel=%b sclk=%b vld=%b ch=%0d smp=%0d last=%b st=%0d err=%0d rd=%0d",
                r.convert_n, r.select_n, r.serial_clock, r.sample_valid, r.channel,
                r.sample, r.last_channel, r.status, r.errors_seen, r.reads_done);
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result with no request pending: %s",
                             $realtime, show(got));
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("[%0t] mismatch on result %0d", $realtime, checked);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known level.
    // ------------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    kind      = 1'b0;
    logic                    busy_pin  = 1'b0;
    logic                    data_pin  = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    convert_n;
    logic                    select_n;
    logic                    serial_clock;
    logic                    sample_valid;
    logic [CHAN_W-1:0]       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                    last_channel;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      errors_seen;
    logic [COUNT_W-1:0]      reads_done;

    readout_scoreboard       board;
    result_t                 seen;
    int                      cycle_count = 0;
    int                      hold_left   = 0;
    // Quiet phases run both channels back to back with no idling.
    bit                      quiet       = 1'b0;
    // Word the fake converter shifts out for the channel being read.
    logic [SAMPLE_W-1:0]     feed_word   = 16'h8000;

    adc_conversion_readout_sequencer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .busy_pin     (busy_pin),
        .data_pin     (data_pin),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .convert_n    (convert_n),
        .select_n     (select_n),
        .serial_clock (serial_clock),
        .sample_valid (sample_valid),
        .channel      (channel),
        .sample       (sample),
        .last_channel (last_channel),
        .status       (status),
        .errors_seen  (errors_seen),
        .reads_done   (reads_done)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Hard stop in case a handshake never completes.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("adc_conversion_readout_sequencer_unit verification failed");
        $finish;
    end

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check every accepted result, then pick the next ready
    // level. Stalls come in runs so the block sees long back-pressure too.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                seen.convert_n    = convert_n;
                seen.select_n     = select_n;
                seen.serial_clock = serial_clock;
                seen.sample_valid = sample_valid;
                seen.channel      = channel;
                seen.sample       = sample;
                seen.last_channel = last_channel;
                seen.status       = status_t'(status);
                seen.errors_seen  = errors_seen;
                seen.reads_done   = reads_done;
                board.check_result(seen);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (quiet || $urandom_range(0, 99) < 70) begin
                out_ready <= 1'b1;
            end
            else begin
                hold_left = pick_gap();
                out_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Hold the request until accepted, then advance the predictor. Leave
    // valid high so a following request can go out on the next edge.
    task automatic push_request(input logic k, input logic b, input logic d);
        int      gap;
        result_t want;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        busy_pin <= b;
        data_pin <= d;
        do @(posedge clk); while (!in_ready);
        want = board.note_request(k, b, d);
        // Load a fresh word for the next channel once this one is done.
        if (want.sample_valid) begin
            case ($urandom_range(0, 5))
                0: feed_word = 16'h8000;
                1: feed_word = 16'h7FFF;
                2: feed_word = 16'h0000;
                3: feed_word = 16'hFFFF;
                default: feed_word = SAMPLE_W'($urandom);
            endcase
        end
    endtask

    // Drive the pins the way a converter would for the predicted phase:
    // starts while idle, busy falling after a while, data from the feed word.
    // A small share of starts mid-sequence and flipped data bits is noise.
    task automatic run_random(input int count);
        logic k;
        logic b;
        logic d;
        for (int i = 0; i < count; i++) begin
            d = 1'($urandom_range(0, 1));
            b = 1'($urandom_range(0, 1));
            case (board.phase)
                PH_IDLE: k = ($urandom_range(0, 9) < 7);
                PH_WAIT: begin
                    k = ($urandom_range(0, 9) == 0);
                    b = ($urandom_range(0, 99) < 75);
                end
                default: begin
                    k = ($urandom_range(0, 9) == 0);
                    if ($urandom_range(0, 9) != 0) d = feed_word[board.bit_idx];
                end
            endcase
            push_request(k, b, d);
        end
    endtask

    // Drop valid and hold until every predicted result is back, then let the
    // pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic load_setting(input logic [TICK_W-1:0] pulse, input logic [TICK_W-1:0] tmo,
                                input logic [TICK_W-1:0] setup, input logic [HALF_W-1:0] half,
                                input logic [CHCNT_W-1:0] chans);
        drain_results();
        write_reg(REG_CONVERT_PULSE, pulse);
        write_reg(REG_BUSY_TIMEOUT, tmo);
        write_reg(REG_SELECT_SETUP, setup);
        write_reg(REG_CLOCK_HALF, {8'd0, half});
        write_reg(REG_CHANNELS, {12'd0, chans});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset settings: idle ticks with every
        // pin combination, a start, starts during the convert pulse (treated
        // as plain ticks), busy held then released, setup and first bits.
        push_request(1'b0, 1'b0, 1'b0);
        push_request(1'b0, 1'b1, 1'b1);
        push_request(1'b0, 1'b0, 1'b1);
        push_request(1'b0, 1'b1, 1'b0);
        push_request(1'b1, 1'b1, 1'b0);
        for (int i = 0; i < 10; i++)
            push_request(i % 3 == 0, 1'b1, 1'(i % 2));
        push_request(1'b1, 1'b1, 1'b1);
        push_request(1'b0, 1'b1, 1'b0);
        push_request(1'b0, 1'b0, 1'b1);
        push_request(1'b0, 1'b0, 1'b0);
        push_request(1'b0, 1'b0, 1'b1);
        push_request(1'b1, 1'b0, 1'b1);
        push_request(1'b0, 1'b0, 1'b0);
        push_request(1'b0, 1'b0, 1'b1);

        // Reset settings: five channels, long busy timeout.
        run_random(200);

        // All registers zero: one-tick pulse, timeout and half period, no
        // setup, channel count zero read as a single channel.
        load_setting(16'd0, 16'd0, 16'd0, 8'd0, 4'd0);
        run_random(150);

        // Full eight channels, back to back on both sides.
        quiet = 1'b1;
        load_setting(16'd1, 16'd1, 16'd1, 8'd1, 4'd8);
        run_random(250);
        quiet = 1'b0;

        load_setting(16'd3, 16'd20, 16'd2, 8'd2, 4'd3);
        run_random(250);

        // Channel count above the maximum clamps to eight; short timeout.
        load_setting(16'd2, 16'd5, 16'd0, 8'd1, 4'd15);
        run_random(300);

        // Top of every range; the pulse alone outlasts this phase.
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd8);
        run_random(60);

        load_setting(TICK_W'($urandom_range(1, 5)), TICK_W'($urandom_range(1, 40)),
                     TICK_W'($urandom_range(0, 4)), HALF_W'($urandom_range(1, 3)),
                     CHCNT_W'($urandom_range(1, 8)));
        run_random(250);

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d requests and %0d results: %0d channel samples, %0d readouts,",
                 board.requests, board.checked, board.samples, board.readouts);
        $display("%0d busy timeouts across seven register settings.", board.timeouts);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("adc_conversion_readout_sequencer_unit verification clean");
        else
            $display("adc_conversion_readout_sequencer_unit verification failed");
        $finish;
    end

endmodule

// ===== adc_conversion_readout_sequencer_unit.f =====
+incdir+hdl
hdl/acrs_pkg.sv
hdl/acrs_cfg_regs.sv
hdl/acrs_core.sv
hdl/acrs_out_reg.sv
hdl/adc_conversion_readout_sequencer_unit.sv
bench/tb_top.sv
